// ===== hw/rtl/cbm_pkg.sv =====
// Shared types and constants of the cartridge bank mapper.
`default_nettype none
package cbm_pkg;

    localparam int CYCLES_PER_LINE = 113;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 9;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROM_BANKS = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN   = 1'b1;
    localparam logic [8:0] ROM_BANKS_RESET = 9'd32;
    localparam logic [8:0] ROM_BANKS_MIN   = 9'd2;
    localparam logic [8:0] ROM_BANKS_CAP   = 9'd32;
    localparam logic [9:0] START_UPPER_MAX = 10'd30;

    localparam logic [15:0] ADDR_BASE_A     = 16'h8000;
    localparam logic [15:0] ADDR_BASE_B     = 16'hB000;
    localparam logic [15:0] ADDR_BASE_C     = 16'hB0FF;
    localparam logic [15:0] ADDR_BASE_D     = 16'hB1FF;
    localparam logic [15:0] ADDR_MIRROR     = 16'h8100;
    localparam logic [15:0] ADDR_IRQ_LO     = 16'h8200;
    localparam logic [15:0] ADDR_IRQ_HI     = 16'h8201;
    localparam logic [15:0] ADDR_PRG_FIRST  = 16'h8300;
    localparam logic [15:0] ADDR_PRG_LAST   = 16'h8302;
    localparam logic [15:0] ADDR_CHR_FIRST  = 16'h8310;
    localparam logic [15:0] ADDR_CHR_LAST   = 16'h8317;
    localparam logic [15:0] ADDR_PRG_PAIR   = 16'h8318;
    localparam logic [15:0] ADDR_SCR_FIRST  = 16'h5101;
    localparam logic [15:0] ADDR_SCR_LAST   = 16'h5103;
    localparam logic [15:0] LOW_READ_MASK   = 16'h5100;

    localparam logic [3:0] SLOT_PPU0      = 4'd4;
    localparam logic [3:0] SLOT_MIRROR    = 4'd12;
    localparam logic [3:0] SLOT_PAIR_LAST = 4'd1;
    localparam logic [3:0] SLOT_CPU_LAST  = 4'd3;
    localparam logic [3:0] SLOT_PPU_LAST  = 4'd11;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        OP_HIGH_WRITE = 3'd0,
        OP_LOW_WRITE  = 3'd1,
        OP_LOW_READ   = 3'd2,
        OP_TICK       = 3'd3,
        OP_START      = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        CMD_SINGLE,
        CMD_PAIR,
        CMD_QUAD
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic        update_valid;
        logic [3:0]  slot;
        logic [9:0]  val_a;
        logic [9:0]  val_b;
        logic [7:0]  read_data;
        logic        irq_fire;
        logic        pattern;
    } cmd_t;

endpackage
`default_nettype wire

// ===== hw/rtl/cbm_if.sv =====
// Handshake channels for mapper items and results.
`default_nettype none
interface cbm_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [15:0] bus_address;
    logic [7:0]  write_data;

    modport source (output valid, output opcode, output bus_address, output write_data,
                    input ready);
    modport sink (input valid, input opcode, input bus_address, input write_data,
                  output ready);
endinterface

interface cbm_out_if;
    logic        valid;
    logic        ready;
    logic        update_valid;
    logic [3:0]  slot;
    logic [9:0]  bank_value;
    logic [7:0]  read_data;
    logic        irq_fire;
    logic        last;

    modport source (output valid, output update_valid, output slot, output bank_value,
                    output read_data, output irq_fire, output last, input ready);
    modport sink (input valid, input update_valid, input slot, input bank_value,
                  input read_data, input irq_fire, input last, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/cbm_front.sv =====
// Front end: accepts items, keeps mapper state and classifies each item into a command.
`default_nettype none
module cbm_front (
    input  logic                             clk,
    input  logic                             rst_n,
    cbm_in_if.sink                           item,
    input  logic                             cfg_we,
    input  logic [cbm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [cbm_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                             push,
    output cbm_pkg::cmd_t                    push_cmd,
    input  logic                             full
);
    import cbm_pkg::*;

    logic [8:0]  rom_banks_reg, rom_banks_next;
    logic        pattern_reg, pattern_next;
    logic [7:0]  base_reg, base_next;
    logic [7:0]  scratch_reg, scratch_next;
    logic [15:0] irq_count_reg, irq_count_next;
    logic        irq_armed_reg, irq_armed_next;

    logic [15:0] addr;
    logic [7:0]  data;
    logic [7:0]  pair_bank;
    logic [9:0]  start_upper;

    assign item.ready = !full;
    assign push       = item.valid && !full;
    assign addr       = item.bus_address;
    assign data       = item.write_data;
    assign pair_bank  = {2'b00, base_reg[5:4], 4'b0000} | data;

    always_comb
    begin
        if (rom_banks_reg >= ROM_BANKS_CAP)
        begin
            start_upper = START_UPPER_MAX;
        end
        else if (rom_banks_reg < ROM_BANKS_MIN)
        begin
            start_upper = '0;
        end
        else
        begin
            start_upper = {1'b0, rom_banks_reg - ROM_BANKS_MIN};
        end
    end

    always_comb
    begin
        rom_banks_next = rom_banks_reg;
        pattern_next   = pattern_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ROM_BANKS: rom_banks_next = cfg_data;
                CFG_PATTERN:   pattern_next   = cfg_data[0];
                default:       rom_banks_next = rom_banks_reg;
            endcase
        end
    end

    always_comb
    begin
        base_next      = base_reg;
        scratch_next   = scratch_reg;
        irq_count_next = irq_count_reg;
        irq_armed_next = irq_armed_reg;
        push_cmd       = '{kind: CMD_SINGLE, default: '0};

        unique case (op_t'(item.opcode))
            OP_HIGH_WRITE:
            begin
                priority if (addr == ADDR_BASE_A || addr == ADDR_BASE_B ||
                             addr == ADDR_BASE_C || addr == ADDR_BASE_D)
                begin
                    base_next             = data;
                    push_cmd.kind         = CMD_QUAD;
                    push_cmd.update_valid = 1'b1;
                    push_cmd.val_a        = {3'b000, data[5:0], 1'b0};
                    push_cmd.val_b        = {3'b000, data[5:4], 4'hF, 1'b0};
                end
                else if (addr == ADDR_MIRROR)
                begin
                    push_cmd.update_valid = 1'b1;
                    push_cmd.slot         = SLOT_MIRROR;
                    push_cmd.val_a        = {8'h00, data[1:0]};
                end
                else if (addr == ADDR_IRQ_LO)
                begin
                    irq_count_next = {irq_count_reg[15:8], data};
                end
                else if (addr == ADDR_IRQ_HI)
                begin
                    irq_count_next = {data, irq_count_reg[7:0]};
                    irq_armed_next = |data;
                end
                else if (addr >= ADDR_PRG_FIRST && addr <= ADDR_PRG_LAST)
                begin
                    push_cmd.update_valid = 1'b1;
                    push_cmd.slot         = {2'b00, addr[1:0]};
                    push_cmd.val_a        = {2'b00, data};
                end
                else if (addr >= ADDR_CHR_FIRST && addr <= ADDR_CHR_LAST)
                begin
                    push_cmd.update_valid = 1'b1;
                    push_cmd.slot         = SLOT_PPU0 + {1'b0, addr[2:0]};
                    push_cmd.val_a        = {base_reg[5:4], data};
                end
                else if (addr == ADDR_PRG_PAIR)
                begin
                    push_cmd.kind         = CMD_PAIR;
                    push_cmd.update_valid = 1'b1;
                    push_cmd.val_a        = {1'b0, pair_bank, 1'b0};
                end
            end
            OP_LOW_WRITE:
            begin
                if (addr >= ADDR_SCR_FIRST && addr <= ADDR_SCR_LAST)
                begin
                    scratch_next = data;
                end
            end
            OP_LOW_READ:
            begin
                push_cmd.read_data = ((addr & LOW_READ_MASK) == LOW_READ_MASK) ?
                                     scratch_reg : addr[15:8];
            end
            OP_TICK:
            begin
                if (irq_armed_reg)
                begin
                    if (irq_count_reg <= 16'(CYCLES_PER_LINE))
                    begin
                        push_cmd.irq_fire = 1'b1;
                        irq_armed_next    = 1'b0;
                    end
                    else
                    begin
                        irq_count_next = irq_count_reg - 16'(CYCLES_PER_LINE);
                    end
                end
            end
            OP_START:
            begin
                base_next             = '0;
                scratch_next          = '0;
                irq_count_next        = '0;
                irq_armed_next        = 1'b0;
                push_cmd.kind         = CMD_QUAD;
                push_cmd.update_valid = 1'b1;
                push_cmd.val_b        = start_upper;
                push_cmd.pattern      = pattern_reg;
            end
            default:
            begin
                push_cmd.kind = CMD_SINGLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_banks_reg <= ROM_BANKS_RESET;
            pattern_reg   <= 1'b1;
            base_reg      <= '0;
            scratch_reg   <= '0;
            irq_count_reg <= '0;
            irq_armed_reg <= 1'b0;
        end
        else
        begin
            rom_banks_reg <= rom_banks_next;
            pattern_reg   <= pattern_next;
            if (push)
            begin
                base_reg      <= base_next;
                scratch_reg   <= scratch_next;
                irq_count_reg <= irq_count_next;
                irq_armed_reg <= irq_armed_next;
            end
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/cbm_queue.sv =====
// Command queue between the front end and the result sequencer.
`default_nettype none
module cbm_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  cbm_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output cbm_pkg::cmd_t head,
    output logic          empty
);
    import cbm_pkg::*;

    cmd_t                   entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/cbm_back.sv =====
// Back end: expands queued commands into result items through an output register.
`default_nettype none
module cbm_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          empty,
    input  cbm_pkg::cmd_t head,
    output logic          pop,
    cbm_out_if.source     result
);
    import cbm_pkg::*;

    logic [3:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic       uv_reg;
    logic [3:0] slot_reg;
    logic [9:0] value_reg;
    logic [7:0] rd_reg;
    logic       irq_reg;
    logic       last_reg;

    logic       load;
    logic       is_last;
    logic [3:0] slot_c;
    logic [9:0] value_c;

    assign load = !empty && (!valid_reg || result.ready);
    assign pop  = load && is_last;

    always_comb
    begin
        slot_c  = idx_reg;
        value_c = head.val_a;
        is_last = 1'b1;
        unique case (head.kind)
            CMD_SINGLE:
            begin
                slot_c  = head.slot;
                value_c = head.val_a;
                is_last = 1'b1;
            end
            CMD_PAIR:
            begin
                value_c = head.val_a + {9'b0, idx_reg[0]};
                is_last = (idx_reg == SLOT_PAIR_LAST);
            end
            CMD_QUAD:
            begin
                if (idx_reg < SLOT_PPU0)
                begin
                    value_c = (idx_reg[1] ? head.val_b : head.val_a) + {9'b0, idx_reg[0]};
                    is_last = (idx_reg == SLOT_CPU_LAST) && !head.pattern;
                end
                else
                begin
                    value_c = {6'b0, idx_reg - SLOT_PPU0};
                    is_last = (idx_reg == SLOT_PPU_LAST);
                end
            end
            default:
            begin
                is_last = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            idx_next   = is_last ? '0 : idx_reg + 1'b1;
            valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            uv_reg    <= head.update_valid;
            slot_reg  <= slot_c;
            value_reg <= value_c;
            rd_reg    <= head.read_data;
            irq_reg   <= head.irq_fire;
            last_reg  <= is_last;
        end
    end

    assign result.valid        = valid_reg;
    assign result.update_valid = uv_reg;
    assign result.slot         = slot_reg;
    assign result.bank_value   = value_reg;
    assign result.read_data    = rd_reg;
    assign result.irq_fire     = irq_reg;
    assign result.last         = last_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/cartridge_bank_mapper_with_irq.sv =====
// Top level of the cartridge bank mapper with scanline IRQ counter.
// The front end takes one item per cycle while its four-entry command queue has
// room, and applies base, scratch and IRQ counter changes at that transfer. The
// back end emits one result per cycle while the receiver is ready, and an item
// has 1 result for reads, ticks, single updates and other writes, 2 for a
// bank pair, 4 for a base write or a start without pattern ROM, 12 for a start
// with it. Results leave in order through the back end's output register,
// with last on the final one of each item.
`default_nettype none
module cartridge_bank_mapper_with_irq (
    input  logic                             clk,
    input  logic                             rst_n,
    cbm_in_if.sink                           item,
    cbm_out_if.source                        result,
    input  logic                             cfg_we,
    input  logic [cbm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [cbm_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import cbm_pkg::*;

    logic push;
    logic full;
    logic pop;
    logic empty;
    cmd_t push_cmd;
    cmd_t head;

    cbm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (full)
    );

    cbm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .head     (head),
        .empty    (empty)
    );

    cbm_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .empty  (empty),
        .head   (head),
        .pop    (pop),
        .result (result)
    );

endmodule
`default_nettype wire
